// ===== rtl/core/deadline_grace_kill_table_top_defines.svh =====
// assertion macros for the deadline table
`ifndef DEADLINE_GRACE_KILL_TABLE_TOP_DEFINES_SVH
`define DEADLINE_GRACE_KILL_TABLE_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define DGK_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define DGK_ASSERT_RST(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define DGK_ASSERT(label, clk, rst_n, prop, msg)
`define DGK_ASSERT_RST(label, clk, prop, msg)
`endif
`endif

// ===== rtl/core/dgk_pkg.sv =====
package dgk_pkg;

  localparam int unsigned Entries = 16;

  localparam logic [2:0] CmdSpawn   = 3'd0;
  localparam logic [2:0] CmdResched = 3'd1;
  localparam logic [2:0] CmdKill    = 3'd2;
  localparam logic [2:0] CmdReport  = 3'd3;
  localparam logic [2:0] CmdTick    = 3'd4;

  localparam logic [2:0] PhPending = 3'd0;
  localparam logic [2:0] PhReady   = 3'd1;
  localparam logic [2:0] PhApplied = 3'd2;
  localparam logic [2:0] PhLate    = 3'd3;
  localparam logic [2:0] PhTimeout = 3'd4;
  localparam logic [2:0] PhKilled  = 3'd5;

  localparam logic [1:0] OutApplied = 2'd0;
  localparam logic [1:0] OutTimeout = 2'd1;
  localparam logic [1:0] OutKilled  = 2'd2;

  localparam logic [1:0] KindAck   = 2'd0;
  localparam logic [1:0] KindEvent = 2'd1;
  localparam logic [1:0] KindDone  = 2'd2;

  typedef struct packed {
    logic [2:0]  phase;
    logic [63:0] due_at;
    logic [31:0] grace_step;
    logic [31:0] grace_limit;
    logic [31:0] grace_taken;
    logic [31:0] kill_countdown;
    logic        kill_pending;
    logic        miss_kill;
    logic        event_armed;
  } entry_t;

  // ram word width, one full entry
  localparam int unsigned EntW = $bits(entry_t);

  // result of evaluating one entry on a tick
  typedef struct packed {
    entry_t     ent;
    logic       emit;
    logic [1:0] outc;
  } eval_t;

  function automatic eval_t evaluate(entry_t e, logic [63:0] beat);
    eval_t r;
    logic [31:0] w;
    logic [64:0] sum;
    r.ent = e;
    r.emit = 1'b0;
    r.outc = OutApplied;
    // kill countdown
    if (e.kill_pending && e.phase != PhKilled) begin
      w = e.kill_countdown;
      if (w != 32'd0) begin
        w = w - 32'd1;
        r.ent.kill_countdown = w;
      end
      if (w == 32'd0) begin
        r.ent.phase = PhKilled;
        r.ent.kill_pending = 1'b0;
        r.emit = 1'b1;
        r.outc = OutKilled;
      end
    end
    // due and grace handling
    if ((r.ent.phase == PhPending || r.ent.phase == PhReady || r.ent.phase == PhLate)
        && beat >= e.due_at) begin
      if (r.ent.phase == PhPending) r.ent.phase = PhReady;
      if (beat > e.due_at && e.grace_limit != 32'd0) begin
        if (e.grace_taken < e.grace_limit) begin
          r.ent.grace_taken = e.grace_taken + 32'd1;
          sum = {1'b0, e.due_at} + {33'd0, e.grace_step};
          r.ent.due_at = sum[64] ? {64{1'b1}} : sum[63:0];
        end else begin
          if (e.miss_kill) begin
            r.ent.phase = PhKilled;
            r.ent.kill_pending = 1'b0;
            r.outc = OutKilled;
          end else begin
            r.ent.phase = PhTimeout;
            r.outc = OutTimeout;
          end
          r.emit = 1'b1;
        end
      end
    end
    // armed event replay
    if (!r.emit && e.event_armed) begin
      if (r.ent.phase == PhApplied) begin
        r.emit = 1'b1;
        r.outc = OutApplied;
      end else if (r.ent.phase == PhTimeout) begin
        r.emit = 1'b1;
        r.outc = OutTimeout;
      end else if (r.ent.phase == PhKilled) begin
        r.emit = 1'b1;
        r.outc = OutKilled;
      end
    end
    if (r.emit) r.ent.event_armed = 1'b0;
    return r;
  endfunction

endpackage

// ===== rtl/core/deadline_grace_kill_table_top.sv =====
// deadline table: per-entry spec in one synchronous ram, valid bits in flops
// reschedule, kill, report: busy through the read and modify states, ack registered from the modify state
// spawn and out-of-range or unknown commands: busy in the read state only, ack registered from it
// tick: one entry per cycle in the scan state, then the done state;
// up to ENTRIES event results then a done result; results cannot be stalled
// reset clears valid bits and control asynchronously; ram contents unused until written
`include "deadline_grace_kill_table_top_defines.svh"
module deadline_grace_kill_table_top #(
  parameter int unsigned ENTRIES = dgk_pkg::Entries
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  command_i,
  input  logic [3:0]  slot_i,
  input  logic [63:0] beat_now_i,
  input  logic [63:0] due_beat_i,
  input  logic [31:0] grace_step_i,
  input  logic [31:0] grace_limit_i,
  input  logic [31:0] wait_beats_i,
  input  logic [31:0] resched_delta_i,
  input  logic        kill_active_i,
  input  logic        miss_kills_i,
  output logic        strobe_o,
  output logic [1:0]  kind_o,
  output logic [3:0]  event_slot_o,
  output logic [1:0]  outcome_o,
  output logic        last_o
);

  localparam int unsigned AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned CW = $clog2(ENTRIES + 1);
  localparam int unsigned RD = 1 << AW;

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StRead = 3'd1;
  localparam logic [2:0] StMod  = 3'd2;
  localparam logic [2:0] StScan = 3'd3;
  localparam logic [2:0] StDone = 3'd4;

  logic [2:0]   state_q, state_d;
  logic [2:0]   cmd_q;
  logic [3:0]   slot_q;
  logic [AW-1:0] slot_a;
  logic [63:0]  beat_q;
  logic [31:0]  wait_q, delta_q;
  logic         kact_q;
  logic [ENTRIES-1:0] valid_q;
  logic [CW-1:0] rd_cnt_q;   // next entry to read
  logic [CW-1:0] ev_cnt_q;   // entry whose data is on the read port
  logic          ev_vld_q;

  logic          we;
  logic [AW-1:0] waddr, raddr;
  dgk_pkg::entry_t wdata, rdata, rent;
  dgk_pkg::eval_t  ev;

  dgk_ram #(.Width(dgk_pkg::EntW), .Depth(RD)) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  assign busy = (state_q != StIdle);
  logic acc;
  assign acc = start && !busy;
  logic slot_in_rng;
  assign slot_in_rng = ({2'b0, slot_q} < 6'(ENTRIES));
  assign slot_a = AW'(slot_q);

  // an invalid entry reads as all zero
  always_comb begin
    rent = rdata;
    if (state_q == StMod && !valid_q[slot_a]) rent = '0;
  end

  assign ev = dgk_pkg::evaluate(rdata, beat_q);
  assign raddr = (state_q == StScan) ? rd_cnt_q[AW-1:0] : slot_a;

  // spawn fields held separately since they do not fit the shared regs
  logic [31:0] cd_q;
  logic        mk_q;
  always_ff @(posedge clk_i) begin
    if (acc) begin
      cd_q <= wait_beats_i;
      mk_q <= miss_kills_i;
    end
  end

  // spawn data path: due in beat_q, step in delta_q, limit in wait_q
  dgk_pkg::entry_t spawn_e;
  always_comb begin
    spawn_e = '0;
    spawn_e.phase = dgk_pkg::PhPending;
    spawn_e.due_at = beat_q;
    spawn_e.grace_step = delta_q;
    spawn_e.grace_limit = wait_q;
    spawn_e.kill_countdown = cd_q;
    spawn_e.kill_pending = kact_q;
    spawn_e.miss_kill = mk_q;
  end

  // write-back selection
  always_comb begin
    we = 1'b0;
    waddr = slot_a;
    wdata = rent;
    if (state_q == StRead && cmd_q == dgk_pkg::CmdSpawn && slot_in_rng) begin
      we = 1'b1;
      wdata = spawn_e;
    end
    if (state_q == StMod) begin
      unique case (cmd_q)
        dgk_pkg::CmdResched: begin
          we = (delta_q != 32'd0);
          wdata.due_at = rent.due_at + {32'd0, delta_q};
        end
        dgk_pkg::CmdKill: begin
          we = 1'b1;
          wdata.kill_pending = kact_q;
          wdata.kill_countdown = wait_q;
        end
        dgk_pkg::CmdReport: begin
          we = 1'b1;
          wdata.phase = dgk_pkg::PhApplied;
          wdata.event_armed = 1'b1;
        end
        default: we = 1'b0;
      endcase
    end
    if (ev_vld_q && valid_q[ev_cnt_q[AW-1:0]]) begin
      we = 1'b1;
      waddr = ev_cnt_q[AW-1:0];
      wdata = ev.ent;
    end
  end

  // request capture
  always_ff @(posedge clk_i) begin
    if (acc) begin
      cmd_q  <= command_i;
      slot_q <= slot_i;
      kact_q <= kill_active_i;
      if (command_i == dgk_pkg::CmdSpawn) begin
        beat_q  <= due_beat_i;
        delta_q <= grace_step_i;
        wait_q  <= grace_limit_i;
      end else begin
        beat_q  <= (beat_now_i == {64{1'b1}}) ? 64'd0 : beat_now_i;
        delta_q <= resched_delta_i;
        wait_q  <= wait_beats_i;
      end
    end
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: if (acc) state_d = (command_i == dgk_pkg::CmdTick) ? StScan : StRead;
      StRead: state_d = (slot_in_rng && (cmd_q == dgk_pkg::CmdResched ||
                cmd_q == dgk_pkg::CmdKill || cmd_q == dgk_pkg::CmdReport)) ? StMod : StIdle;
      StMod:  state_d = StIdle;
      StScan: if (rd_cnt_q == CW'(ENTRIES) && !ev_vld_q) state_d = StDone;
      StDone: state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  logic ack_now;
  assign ack_now = (state_q == StRead && state_d == StIdle) || state_q == StMod;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      valid_q  <= '0;
      rd_cnt_q <= '0;
      ev_cnt_q <= '0;
      ev_vld_q <= 1'b0;
      strobe_o <= 1'b0;
      kind_o <= dgk_pkg::KindAck;
      event_slot_o <= '0;
      outcome_o <= dgk_pkg::OutApplied;
      last_o <= 1'b0;
    end else begin
      state_q  <= state_d;
      if (acc) begin
        rd_cnt_q <= '0;
        ev_vld_q <= 1'b0;
      end else if (state_q == StScan) begin
        // scan: one read per cycle, evaluate next cycle
        ev_vld_q <= (rd_cnt_q != CW'(ENTRIES));
        ev_cnt_q <= rd_cnt_q;
        if (rd_cnt_q != CW'(ENTRIES)) rd_cnt_q <= rd_cnt_q + CW'(1);
      end
      // result register: ack, done or one tick event
      if (ack_now) begin
        strobe_o <= 1'b1;
        kind_o <= dgk_pkg::KindAck;
        event_slot_o <= slot_q;
        outcome_o <= dgk_pkg::OutApplied;
        last_o <= 1'b1;
      end else if (state_q == StDone) begin
        strobe_o <= 1'b1;
        kind_o <= dgk_pkg::KindDone;
        event_slot_o <= '0;
        outcome_o <= dgk_pkg::OutApplied;
        last_o <= 1'b1;
      end else if (ev_vld_q && valid_q[ev_cnt_q[AW-1:0]] && ev.emit) begin
        strobe_o <= 1'b1;
        kind_o <= dgk_pkg::KindEvent;
        event_slot_o <= 4'(ev_cnt_q);
        outcome_o <= ev.outc;
        last_o <= 1'b0;
      end else begin
        strobe_o <= 1'b0;
      end
      // valid bits
      if (state_q == StRead && slot_in_rng && cmd_q == dgk_pkg::CmdSpawn)
        valid_q[slot_a] <= 1'b1;
      else if (state_q == StMod && we) valid_q[slot_a] <= 1'b1;
    end
  end

  `DGK_ASSERT(a_start_idle, clk_i, rst_ni, acc |=> busy, "request not taken")
  `DGK_ASSERT(a_done_last, clk_i, rst_ni,
    (strobe_o && kind_o == dgk_pkg::KindDone) |-> last_o, "done without last")
  `DGK_ASSERT(a_event_notlast, clk_i, rst_ni,
    (strobe_o && kind_o == dgk_pkg::KindEvent) |-> !last_o, "event marked last")
  `DGK_ASSERT(a_idle_quiet, clk_i, rst_ni,
    (state_q == StIdle && $past(state_q) == StIdle) |-> !strobe_o, "stray result")

endmodule

// ===== rtl/core/dgk_ram.sv =====
module dgk_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // write port and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end

endmodule
